/* hdl/kafs_pkg.sv */
// Shared types, constants and the step microprogram of the angle fusion filter.
package kafs_pkg;

    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SLOT_W      = 6;
    localparam int PC_W        = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_Q_ANGLE    = 3'd0;
    localparam t_cfg_idx CFG_Q_RATE     = 3'd1;
    localparam t_cfg_idx CFG_INIT_ANGLE = 3'd2;
    localparam t_cfg_idx CFG_INIT_RATE  = 3'd3;
    localparam t_cfg_idx CFG_INIT_P_ANG = 3'd4;
    localparam t_cfg_idx CFG_INIT_P_RAT = 3'd5;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC} t_state;

    typedef enum logic [3:0] {
        U_LD, U_ADD, U_SUB, U_NEG, U_MUL, U_DIV, U_WRAP, U_BRZ, U_OUT
    } t_uop;

    typedef enum logic [3:0] {
        E_ZA, E_ZG, E_ZC, E_DT, E_HA, E_HG, E_HC, E_QA, E_QR,
        E_IANG, E_IRATE, E_IPA, E_IPR, E_ZERO, E_ONE
    } t_ext;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [PC_W-1:0]   t_pc;

    typedef struct packed {
        t_uop  op;
        t_ext  ext;
        t_slot dst;
        t_slot a;
        t_slot b;
    } t_uinst;

    // scratch register file slots
    localparam t_slot SL_ANG = 6'd0,  SL_RAT = 6'd1,  SL_P00 = 6'd2,  SL_P01 = 6'd3;
    localparam t_slot SL_P10 = 6'd4,  SL_P11 = 6'd5,  SL_ZA  = 6'd6,  SL_ZG  = 6'd7;
    localparam t_slot SL_ZC  = 6'd8,  SL_DT  = 6'd9,  SL_HA  = 6'd10, SL_HG  = 6'd11;
    localparam t_slot SL_HC  = 6'd12, SL_FA  = 6'd13, SL_FG  = 6'd14, SL_FC  = 6'd15;
    localparam t_slot SL_C   = 6'd16, SL_DET = 6'd17, SL_T1  = 6'd18, SL_T2  = 6'd19;
    localparam t_slot SL_PP  = 6'd20, SL_PG  = 6'd21, SL_U   = 6'd22, SL_V   = 6'd23;
    localparam t_slot SL_N00 = 6'd24, SL_N01 = 6'd25, SL_N02 = 6'd26, SL_N10 = 6'd27;
    localparam t_slot SL_N11 = 6'd28, SL_N12 = 6'd29, SL_N21 = 6'd30, SL_N22 = 6'd31;
    localparam t_slot SL_F00 = 6'd32, SL_F01 = 6'd33, SL_F02 = 6'd34, SL_F10 = 6'd35;
    localparam t_slot SL_F11 = 6'd36, SL_F12 = 6'd37, SL_F20 = 6'd38, SL_F21 = 6'd39;
    localparam t_slot SL_F22 = 6'd40, SL_K00 = 6'd41, SL_K01 = 6'd42, SL_K02 = 6'd43;
    localparam t_slot SL_K10 = 6'd44, SL_K11 = 6'd45, SL_K12 = 6'd46, SL_EA  = 6'd47;
    localparam t_slot SL_EG  = 6'd48, SL_EC  = 6'd49, SL_S0  = 6'd50, SL_S1  = 6'd51;
    localparam t_slot SL_T0  = 6'd52, SL_TT1 = 6'd53, SL_X   = 6'd54;

    localparam t_pc PC_RELOAD = 8'd0;
    localparam t_pc PC_STEP   = 8'd8;
    localparam t_pc PC_OUT    = 8'd147;

    function automatic t_uinst ua(input t_uop op, input t_slot d, input t_slot a,
                                  input t_slot b);
        t_uinst u;
        u.op = op; u.ext = E_ZERO; u.dst = d; u.a = a; u.b = b;
        return u;
    endfunction

    function automatic t_uinst ld(input t_slot d, input t_ext e);
        t_uinst u;
        u = ua(U_LD, d, d, d);
        u.ext = e;
        return u;
    endfunction

    function automatic t_uinst f_ucode(input t_pc pc);
        t_uinst u;
        case (pc)
            // reload
            8'd0:   u = ld(SL_ANG, E_IANG);
            8'd1:   u = ua(U_WRAP, SL_ANG, SL_ANG, SL_ANG);
            8'd2:   u = ld(SL_RAT, E_IRATE);
            8'd3:   u = ld(SL_P00, E_IPA);
            8'd4:   u = ld(SL_P01, E_ZERO);
            8'd5:   u = ld(SL_P10, E_ZERO);
            8'd6:   u = ld(SL_P11, E_IPR);
            8'd7:   u = ua(U_OUT, SL_ANG, SL_ANG, SL_RAT);
            // filter step
            8'd8:   u = ld(SL_ZA, E_ZA);
            8'd9:   u = ld(SL_ZG, E_ZG);
            8'd10:  u = ld(SL_ZC, E_ZC);
            8'd11:  u = ld(SL_DT, E_DT);
            8'd12:  u = ld(SL_HA, E_HA);
            8'd13:  u = ld(SL_HG, E_HG);
            8'd14:  u = ld(SL_HC, E_HC);
            8'd15:  u = ua(U_ADD, SL_FA, SL_P00, SL_HA);
            8'd16:  u = ua(U_ADD, SL_FG, SL_P11, SL_HG);
            8'd17:  u = ua(U_ADD, SL_FC, SL_P00, SL_HC);
            8'd18:  u = ua(U_MUL, SL_C, SL_P01, SL_P10);
            8'd19:  u = ua(U_ADD, SL_T1, SL_P00, SL_P00);
            8'd20:  u = ua(U_MUL, SL_DET, SL_T1, SL_C);
            8'd21:  u = ua(U_MUL, SL_T1, SL_P00, SL_P00);
            8'd22:  u = ua(U_MUL, SL_T1, SL_T1, SL_FG);
            8'd23:  u = ua(U_SUB, SL_DET, SL_DET, SL_T1);
            8'd24:  u = ua(U_MUL, SL_T1, SL_C, SL_FA);
            8'd25:  u = ua(U_SUB, SL_DET, SL_DET, SL_T1);
            8'd26:  u = ua(U_MUL, SL_T1, SL_C, SL_FC);
            8'd27:  u = ua(U_SUB, SL_DET, SL_DET, SL_T1);
            8'd28:  u = ua(U_MUL, SL_T1, SL_FA, SL_FC);
            8'd29:  u = ua(U_MUL, SL_T1, SL_T1, SL_FG);
            8'd30:  u = ua(U_ADD, SL_DET, SL_DET, SL_T1);
            8'd31:  u = ua(U_BRZ, SL_DET, SL_DET, SL_DET);
            8'd32:  u = ua(U_MUL, SL_PP, SL_P00, SL_P11);
            8'd33:  u = ua(U_MUL, SL_PG, SL_P00, SL_HG);
            8'd34:  u = ua(U_MUL, SL_T1, SL_DT, SL_P10);
            8'd35:  u = ua(U_ADD, SL_U, SL_T1, SL_P00);
            8'd36:  u = ua(U_MUL, SL_T1, SL_DT, SL_P11);
            8'd37:  u = ua(U_ADD, SL_V, SL_T1, SL_P01);
            8'd38:  u = ua(U_SUB, SL_T1, SL_PP, SL_C);
            8'd39:  u = ua(U_ADD, SL_T1, SL_T1, SL_PG);
            8'd40:  u = ua(U_MUL, SL_T2, SL_P11, SL_HC);
            8'd41:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd42:  u = ua(U_MUL, SL_T2, SL_HC, SL_HG);
            8'd43:  u = ua(U_ADD, SL_N00, SL_T1, SL_T2);
            8'd44:  u = ua(U_MUL, SL_T1, SL_P01, SL_HC);
            8'd45:  u = ua(U_NEG, SL_N01, SL_T1, SL_T1);
            8'd46:  u = ua(U_SUB, SL_T1, SL_C, SL_PP);
            8'd47:  u = ua(U_SUB, SL_N02, SL_T1, SL_PG);
            8'd48:  u = ua(U_MUL, SL_T1, SL_P10, SL_HC);
            8'd49:  u = ua(U_NEG, SL_N10, SL_T1, SL_T1);
            8'd50:  u = ua(U_MUL, SL_T1, SL_P00, SL_HA);
            8'd51:  u = ua(U_MUL, SL_T2, SL_P00, SL_HC);
            8'd52:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd53:  u = ua(U_MUL, SL_T2, SL_HA, SL_HC);
            8'd54:  u = ua(U_ADD, SL_N11, SL_T1, SL_T2);
            8'd55:  u = ua(U_MUL, SL_T1, SL_P10, SL_HA);
            8'd56:  u = ua(U_NEG, SL_N12, SL_T1, SL_T1);
            8'd57:  u = ua(U_MUL, SL_T1, SL_P01, SL_HA);
            8'd58:  u = ua(U_NEG, SL_N21, SL_T1, SL_T1);
            8'd59:  u = ua(U_SUB, SL_T1, SL_PP, SL_C);
            8'd60:  u = ua(U_ADD, SL_T1, SL_T1, SL_PG);
            8'd61:  u = ua(U_MUL, SL_T2, SL_P11, SL_HA);
            8'd62:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd63:  u = ua(U_MUL, SL_T2, SL_HA, SL_HG);
            8'd64:  u = ua(U_ADD, SL_N22, SL_T1, SL_T2);
            8'd65:  u = ua(U_DIV, SL_F00, SL_N00, SL_DET);
            8'd66:  u = ua(U_DIV, SL_F01, SL_N01, SL_DET);
            8'd67:  u = ua(U_DIV, SL_F02, SL_N02, SL_DET);
            8'd68:  u = ua(U_DIV, SL_F10, SL_N10, SL_DET);
            8'd69:  u = ua(U_DIV, SL_F11, SL_N11, SL_DET);
            8'd70:  u = ua(U_DIV, SL_F12, SL_N12, SL_DET);
            8'd71:  u = ua(U_DIV, SL_F20, SL_N02, SL_DET);
            8'd72:  u = ua(U_DIV, SL_F21, SL_N21, SL_DET);
            8'd73:  u = ua(U_DIV, SL_F22, SL_N22, SL_DET);
            8'd74:  u = ua(U_MUL, SL_T1, SL_F00, SL_U);
            8'd75:  u = ua(U_MUL, SL_T2, SL_F10, SL_V);
            8'd76:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd77:  u = ua(U_MUL, SL_T2, SL_F20, SL_U);
            8'd78:  u = ua(U_ADD, SL_K00, SL_T1, SL_T2);
            8'd79:  u = ua(U_MUL, SL_T1, SL_F00, SL_P10);
            8'd80:  u = ua(U_MUL, SL_T2, SL_F10, SL_P11);
            8'd81:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd82:  u = ua(U_MUL, SL_T2, SL_F20, SL_P10);
            8'd83:  u = ua(U_ADD, SL_K10, SL_T1, SL_T2);
            8'd84:  u = ua(U_MUL, SL_T1, SL_F01, SL_U);
            8'd85:  u = ua(U_MUL, SL_T2, SL_F11, SL_V);
            8'd86:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd87:  u = ua(U_MUL, SL_T2, SL_F21, SL_U);
            8'd88:  u = ua(U_ADD, SL_K01, SL_T1, SL_T2);
            8'd89:  u = ua(U_MUL, SL_T1, SL_F01, SL_P10);
            8'd90:  u = ua(U_MUL, SL_T2, SL_F11, SL_P11);
            8'd91:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd92:  u = ua(U_MUL, SL_T2, SL_F21, SL_P10);
            8'd93:  u = ua(U_ADD, SL_K11, SL_T1, SL_T2);
            8'd94:  u = ua(U_MUL, SL_T1, SL_F02, SL_U);
            8'd95:  u = ua(U_MUL, SL_T2, SL_F12, SL_V);
            8'd96:  u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd97:  u = ua(U_MUL, SL_T2, SL_F22, SL_U);
            8'd98:  u = ua(U_ADD, SL_K02, SL_T1, SL_T2);
            8'd99:  u = ua(U_MUL, SL_T1, SL_F02, SL_P10);
            8'd100: u = ua(U_MUL, SL_T2, SL_F12, SL_P11);
            8'd101: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd102: u = ua(U_MUL, SL_T2, SL_F22, SL_P10);
            8'd103: u = ua(U_ADD, SL_K12, SL_T1, SL_T2);
            8'd104: u = ua(U_SUB, SL_EA, SL_ZA, SL_ANG);
            8'd105: u = ua(U_SUB, SL_EG, SL_ZG, SL_RAT);
            8'd106: u = ua(U_SUB, SL_EC, SL_ZC, SL_ANG);
            8'd107: u = ua(U_MUL, SL_T1, SL_DT, SL_RAT);
            8'd108: u = ua(U_MUL, SL_T2, SL_K00, SL_EA);
            8'd109: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd110: u = ua(U_MUL, SL_T2, SL_K01, SL_EG);
            8'd111: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd112: u = ua(U_MUL, SL_T2, SL_K02, SL_EC);
            8'd113: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd114: u = ua(U_ADD, SL_ANG, SL_T1, SL_ANG);
            8'd115: u = ua(U_MUL, SL_T1, SL_K10, SL_EA);
            8'd116: u = ua(U_MUL, SL_T2, SL_K11, SL_EG);
            8'd117: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd118: u = ua(U_MUL, SL_T2, SL_K12, SL_EC);
            8'd119: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd120: u = ua(U_ADD, SL_RAT, SL_T1, SL_RAT);
            8'd121: u = ua(U_WRAP, SL_ANG, SL_ANG, SL_ANG);
            8'd122: u = ua(U_NEG, SL_T1, SL_K00, SL_K00);
            8'd123: u = ua(U_SUB, SL_T1, SL_T1, SL_K02);
            8'd124: u = ld(SL_T2, E_ONE);
            8'd125: u = ua(U_ADD, SL_S0, SL_T1, SL_T2);
            8'd126: u = ua(U_NEG, SL_T1, SL_K10, SL_K10);
            8'd127: u = ua(U_SUB, SL_S1, SL_T1, SL_K12);
            8'd128: u = ua(U_SUB, SL_T0, SL_DT, SL_K01);
            8'd129: u = ld(SL_T2, E_ONE);
            8'd130: u = ua(U_SUB, SL_TT1, SL_T2, SL_K11);
            8'd131: u = ld(SL_T1, E_QA);
            8'd132: u = ua(U_MUL, SL_T2, SL_T0, SL_V);
            8'd133: u = ua(U_ADD, SL_T1, SL_T1, SL_T2);
            8'd134: u = ua(U_MUL, SL_T2, SL_U, SL_S0);
            8'd135: u = ua(U_ADD, SL_P00, SL_T1, SL_T2);
            8'd136: u = ua(U_MUL, SL_T1, SL_TT1, SL_V);
            8'd137: u = ua(U_MUL, SL_T2, SL_S1, SL_U);
            8'd138: u = ua(U_ADD, SL_P01, SL_T1, SL_T2);
            8'd139: u = ua(U_MUL, SL_T1, SL_P10, SL_S1);
            8'd140: u = ua(U_MUL, SL_T2, SL_P11, SL_TT1);
            8'd141: u = ua(U_ADD, SL_X, SL_T1, SL_T2);
            8'd142: u = ua(U_MUL, SL_T1, SL_P10, SL_S0);
            8'd143: u = ua(U_MUL, SL_T2, SL_P11, SL_T0);
            8'd144: u = ua(U_ADD, SL_P10, SL_T1, SL_T2);
            8'd145: u = ld(SL_T1, E_QR);
            8'd146: u = ua(U_ADD, SL_P11, SL_X, SL_T1);
            default: u = ua(U_OUT, SL_ANG, SL_ANG, SL_RAT);
        endcase
        return u;
    endfunction

endpackage

/* hdl/kalman_angle_fusion_step_top.sv */
// Two-state angle/rate Kalman filter run by a microprogram over bit-serial units.
//
//  channel   dir  tdata (lsb first)                                      tuser
//  s_axis    in   accel_angle, gyro_rate, compass_angle, time_step,      action
//                 var_accel, var_gyro, var_compass, zero pad
//  m_axis    out  angle_out, rate_out, zero pad                          singular
//  cfg       in   i_cfg_idx selects register, i_cfg_wdata value, i_cfg_we
//
// A plain microinstruction reads its operands, then executes. A multiply adds
// a setup step, then shifts and adds one bit a cycle; a divide adds a setup step,
// then restoring division one quotient bit a cycle; a wrap adds a setup step, then
// adds or subtracts 2*pi step by step until the angle lies in 0 to 2*pi. A filter
// step has 140 microinstructions (56 multiplies, 9 divides); a singular step
// branches from its determinant check to the output. After reset the reload
// program runs once before s_axis_tready rises. The result register lets a
// new beat be taken while the previous result waits on m_axis_tready.
module kalman_angle_fusion_step_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // accel_angle, gyro_rate, compass_angle, time_step, var_accel, var_gyro, var_compass
    input  logic [kafs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // angle_out, rate_out
    output logic [kafs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // singular
    output logic                               m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [kafs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kafs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import kafs_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [63:0] FX_MAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] FX_MIN64 = -(64'sd1 <<< (W - 1));
    localparam logic [W-1:0] FX_MAXV = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] FX_MINV = {1'b1, {(W - 1){1'b0}}};
    localparam logic [2*W-1:0] MAG_LIM = (2*W)'(1) << (W - 1);
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TWO_PI64 = ((TWO_PI_Q60 >> (59 - F)) + 64'd1) >> 1;
    localparam logic [W-1:0] TWO_PI = TWO_PI64[W-1:0];

    function automatic logic [W-1:0] f_sat64(input logic signed [63:0] x);
        logic [W-1:0] r;
        if (x > FX_MAX64) r = FX_MAXV;
        else if (x < FX_MIN64) r = FX_MINV;
        else r = x[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] f_addsat(input logic [W-1:0] a, input logic [W-1:0] b,
                                              input logic sub);
        logic [W:0] s;
        logic [W-1:0] r;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) r = s[W] ? FX_MINV : FX_MAXV;
        else r = s[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + W'(1)) : a;
    endfunction

    function automatic logic [W-1:0] f_from_mag(input logic neg, input logic [2*W-1:0] m);
        logic [W-1:0] r;
        if (neg) r = (m >= MAG_LIM) ? FX_MINV : (~m[W-1:0] + W'(1));
        else r = (m >= MAG_LIM) ? FX_MAXV : m[W-1:0];
        return r;
    endfunction

    function automatic logic [63:0] f_sext64(input logic [W-1:0] a);
        return {{(64 - W){a[W-1]}}, a};
    endfunction

    t_state r_state, n_state;
    t_pc    r_pc;
    logic   r_init, r_boot, r_sing;
    logic   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic   r_out_user;

    logic [30:0] r_cfg_qa, r_cfg_qr, r_cfg_ipa, r_cfg_ipr;
    logic [26:0] r_cfg_iang;
    logic [31:0] r_cfg_irate;

    logic [31:0] r_za, r_zg, r_zc;
    logic [30:0] r_dt, r_ha, r_hg, r_hc;

    logic [W-1:0] r_mem [0:(1 << SLOT_W) - 1];
    logic [W-1:0] r_opa, r_opb;

    logic [W-1:0]   r_ma, r_mb, r_dm, r_rem, r_q, r_x;
    logic [2*W-1:0] r_prod;
    logic [NW-1:0]  r_num;
    logic [CW-1:0]  r_cnt;
    logic           r_neg, r_big;

    t_uinst       w_u;
    logic [W-1:0] w_ext, w_res;
    logic         w_done, w_wr, w_above, w_ge;
    logic [W:0]   w_msum, w_trial, w_diff;
    logic [63:0]  w_ang64, w_rat64;

    assign w_u     = f_ucode(r_pc);
    assign w_above = $signed(r_x) > $signed(TWO_PI);
    assign w_msum  = {1'b0, r_prod[2*W-1:W]} + (r_mb[0] ? {1'b0, r_ma} : '0);
    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dm};
    assign w_diff  = w_trial - {1'b0, r_dm};
    assign w_ang64 = f_sext64(r_opa);
    assign w_rat64 = f_sext64(r_opb);

    always_comb begin
        case (w_u.ext)
            E_ZA:    w_ext = f_sat64({{32{r_za[31]}}, r_za});
            E_ZG:    w_ext = f_sat64({{32{r_zg[31]}}, r_zg});
            E_ZC:    w_ext = f_sat64({{32{r_zc[31]}}, r_zc});
            E_DT:    w_ext = f_sat64({33'd0, r_dt});
            E_HA:    w_ext = f_sat64({33'd0, r_ha});
            E_HG:    w_ext = f_sat64({33'd0, r_hg});
            E_HC:    w_ext = f_sat64({33'd0, r_hc});
            E_QA:    w_ext = f_sat64({33'd0, r_cfg_qa});
            E_QR:    w_ext = f_sat64({33'd0, r_cfg_qr});
            E_IANG:  w_ext = f_sat64({37'd0, r_cfg_iang});
            E_IRATE: w_ext = f_sat64({{32{r_cfg_irate[31]}}, r_cfg_irate});
            E_IPA:   w_ext = f_sat64({33'd0, r_cfg_ipa});
            E_IPR:   w_ext = f_sat64({33'd0, r_cfg_ipr});
            E_ONE:   w_ext = f_sat64(64'sd1 <<< F);
            default: w_ext = '0;
        endcase
    end

    // completion and result of the current microinstruction
    always_comb begin
        w_done = 1'b1;
        w_wr   = 1'b0;
        w_res  = r_opa;
        case (w_u.op)
            U_LD: begin
                w_wr  = 1'b1;
                w_res = w_ext;
            end
            U_ADD: begin
                w_wr  = 1'b1;
                w_res = f_addsat(r_opa, r_opb, 1'b0);
            end
            U_SUB: begin
                w_wr  = 1'b1;
                w_res = f_addsat(r_opa, r_opb, 1'b1);
            end
            U_NEG: begin
                w_wr  = 1'b1;
                w_res = f_addsat('0, r_opa, 1'b1);
            end
            U_MUL: begin
                w_wr   = 1'b1;
                w_done = !r_init && (r_cnt == '0);
                w_res  = f_from_mag(r_neg, r_prod >> F);
            end
            U_DIV: begin
                w_wr   = 1'b1;
                w_done = !r_init && (r_cnt == '0);
                w_res  = f_from_mag(r_neg, r_big ? '1 : {{W{1'b0}}, r_q});
            end
            U_WRAP: begin
                w_wr   = 1'b1;
                w_done = !r_init && !w_above && !r_x[W-1];
                w_res  = r_x;
            end
            U_BRZ:   w_done = 1'b1;
            U_OUT:   w_done = r_boot || !r_out_valid || m_axis_tready;
            default: w_done = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_READ;
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                if (w_done) n_state = (w_u.op == U_OUT) ? ST_IDLE : ST_READ;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_data;
        m_axis_tuser  = r_out_user;
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READ;
            r_pc        <= PC_RELOAD;
            r_boot      <= 1'b1;
            r_init      <= 1'b0;
            r_sing      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_qa    <= 31'd16777;
            r_cfg_qr    <= 31'd16777;
            r_cfg_iang  <= '0;
            r_cfg_irate <= '0;
            r_cfg_ipa   <= 31'd16777216;
            r_cfg_ipr   <= 31'd16777216;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Q_ANGLE:    r_cfg_qa    <= i_cfg_wdata[30:0];
                    CFG_Q_RATE:     r_cfg_qr    <= i_cfg_wdata[30:0];
                    CFG_INIT_ANGLE: r_cfg_iang  <= i_cfg_wdata[26:0];
                    CFG_INIT_RATE:  r_cfg_irate <= i_cfg_wdata;
                    CFG_INIT_P_ANG: r_cfg_ipa   <= i_cfg_wdata[30:0];
                    CFG_INIT_P_RAT: r_cfg_ipr   <= i_cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (r_state == ST_EXEC && w_done && w_u.op == U_OUT && !r_boot)
                r_out_valid <= 1'b1;
            else if (r_out_valid && m_axis_tready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pc   <= s_axis_tuser ? PC_RELOAD : PC_STEP;
                        r_sing <= 1'b0;
                    end
                end
                ST_READ: r_init <= 1'b1;
                ST_EXEC: begin
                    r_init <= 1'b0;
                    if (w_done) begin
                        case (w_u.op)
                            U_BRZ: begin
                                // zero determinant: hold the state and report it
                                if (r_opa == '0) begin
                                    r_pc   <= PC_OUT;
                                    r_sing <= 1'b1;
                                end else begin
                                    r_pc <= r_pc + t_pc'(1);
                                end
                            end
                            U_OUT: r_boot <= 1'b0;
                            default: r_pc <= r_pc + t_pc'(1);
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // register file: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_opa <= r_mem[w_u.a];
            r_opb <= r_mem[w_u.b];
        end
        if (r_state == ST_EXEC && w_done && w_wr) r_mem[w_u.dst] <= w_res;
    end

    // input capture, serial units and result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_za <= s_axis_tdata[31:0];
            r_zg <= s_axis_tdata[63:32];
            r_zc <= s_axis_tdata[95:64];
            r_dt <= s_axis_tdata[126:96];
            r_ha <= s_axis_tdata[157:127];
            r_hg <= s_axis_tdata[188:158];
            r_hc <= s_axis_tdata[219:189];
        end
        if (r_state == ST_EXEC) begin
            if (r_init) begin
                r_neg <= r_opa[W-1] ^ r_opb[W-1];
                r_x   <= r_opa;
                case (w_u.op)
                    U_MUL: begin
                        r_ma   <= f_mag(r_opa);
                        r_mb   <= f_mag(r_opb);
                        r_prod <= '0;
                        r_cnt  <= CW'(W);
                    end
                    U_DIV: begin
                        r_num <= {f_mag(r_opa), {F{1'b0}}};
                        r_dm  <= f_mag(r_opb);
                        r_rem <= '0;
                        r_q   <= '0;
                        r_big <= 1'b0;
                        r_cnt <= CW'(NW);
                    end
                    default: ;
                endcase
            end else begin
                case (w_u.op)
                    U_MUL: begin
                        if (r_cnt != '0) begin
                            r_prod <= {w_msum, r_prod[W-1:1]};
                            r_mb   <= r_mb >> 1;
                            r_cnt  <= r_cnt - CW'(1);
                        end
                    end
                    U_DIV: begin
                        if (r_cnt != '0) begin
                            r_num <= r_num << 1;
                            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
                            r_q   <= {r_q[W-2:0], w_ge};
                            // a quotient bit past the data width only means saturation
                            r_big <= r_big | r_q[W-1];
                            r_cnt <= r_cnt - CW'(1);
                        end
                    end
                    U_WRAP: begin
                        if (w_above) r_x <= r_x - TWO_PI;
                        else if (r_x[W-1]) r_x <= r_x + TWO_PI;
                    end
                    default: ;
                endcase
            end
            if (w_u.op == U_OUT && w_done && !r_boot) begin
                r_out_data <= {5'd0, w_rat64[31:0], w_ang64[26:0]};
                r_out_user <= r_sing;
            end
        end
    end

endmodule

/* bench/kalman_angle_fusion_step_top_test.sv */
// Self-checking testbench of the angle/rate fusion filter: predicted results vs. the block.
module kalman_angle_fusion_step_top_test;
    import kafs_pkg::*;

    localparam longint FX_HI    = 64'sd2147483647;
    localparam longint FX_LO    = -64'sd2147483648;
    localparam longint TWO_PI   = 64'sd105414357;
    localparam longint FX_ONE   = 64'sd16777216;
    localparam int     FRAC     = 24;
    localparam int     WD_LIMIT = 60000;
    localparam int     N_REGS   = 6;

    typedef struct {
        logic               reload;
        logic signed [31:0] accel;
        logic signed [31:0] gyro;
        logic signed [31:0] compass;
        logic [30:0]        dt;
        logic [30:0]        v_accel;
        logic [30:0]        v_gyro;
        logic [30:0]        v_compass;
    } t_meas;

    typedef struct {
        logic [26:0] angle;
        logic [31:0] rate;
        logic        singular;
    } t_fused;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata = '0;

    kalman_angle_fusion_step_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    initial forever #5 i_clk = ~i_clk;

    // filter model state
    longint kf_reg [N_REGS];
    longint est_ang, est_rate, p_aa, p_ar, p_ra, p_rr;

    t_fused fused_q[$];
    int     errors = 0;
    int     n_steps = 0, n_reloads = 0, n_singular = 0, n_results = 0;
    int     send_idle = 0, rcv_idle = 0;
    int     wd_cnt = 0;

    function automatic longint fx_sat(longint x);
        if (x > FX_HI) return FX_HI;
        if (x < FX_LO) return FX_LO;
        return x;
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return fx_sat(a + b);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return fx_sat(a - b);
    endfunction

    function automatic longint fx_neg(longint a);
        return fx_sat(-a);
    endfunction

    // truncation toward zero on the magnitude
    function automatic longint fx_mul(longint a, longint b);
        longint p, m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> FRAC;
        return fx_sat((p < 0) ? -m : m);
    endfunction

    function automatic longint fx_div(longint n, longint d);
        longint nm, dm, q;
        nm = ((n < 0) ? -n : n) << FRAC;
        dm = (d < 0) ? -d : d;
        q = nm / dm;
        return fx_sat(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function automatic longint fx_wrap(longint x);
        if (x > TWO_PI) x -= ((x - 1) / TWO_PI) * TWO_PI;
        else if (x < 0) x += ((-x + TWO_PI - 1) / TWO_PI) * TWO_PI;
        return x;
    endfunction

    function automatic void load_filter();
        est_ang  = fx_wrap(kf_reg[CFG_INIT_ANGLE]);
        est_rate = fx_sat(longint'(signed'(kf_reg[CFG_INIT_RATE][31:0])));
        p_aa = kf_reg[CFG_INIT_P_ANG];
        p_ar = 0;
        p_ra = 0;
        p_rr = kf_reg[CFG_INIT_P_RAT];
    endfunction

    function automatic t_fused fuse_step(t_meas m);
        t_fused r;
        longint za, zg, zc, dt, ha, hg, hc, p00, p01, p10, p11;
        longint fa, fg, fc, c, det, pp, pg, u, v, ea, eg, ec, na, nr, s0, s1, t0, t1;
        longint n [3][3];
        longint fi [3][3];
        longint k [2][3];
        r.singular = 1'b0;
        if (m.reload) begin
            load_filter();
            n_reloads++;
        end else begin
            za = m.accel; zg = m.gyro; zc = m.compass;
            dt = m.dt; ha = m.v_accel; hg = m.v_gyro; hc = m.v_compass;
            p00 = p_aa; p01 = p_ar; p10 = p_ra; p11 = p_rr;
            fa = fx_add(p00, ha); fg = fx_add(p11, hg); fc = fx_add(p00, hc);
            c = fx_mul(p01, p10);
            det = fx_mul(fx_add(p00, p00), c);
            det = fx_sub(det, fx_mul(fx_mul(p00, p00), fg));
            det = fx_sub(det, fx_mul(c, fa));
            det = fx_sub(det, fx_mul(c, fc));
            det = fx_add(det, fx_mul(fx_mul(fa, fc), fg));
            n_steps++;
            if (det == 0) begin
                r.singular = 1'b1;
                n_singular++;
            end else begin
                pp = fx_mul(p00, p11);
                pg = fx_mul(p00, hg);
                u = fx_add(fx_mul(dt, p10), p00);
                v = fx_add(fx_mul(dt, p11), p01);
                n[0][0] = fx_add(fx_add(fx_add(fx_sub(pp, c), pg), fx_mul(p11, hc)),
                                 fx_mul(hc, hg));
                n[0][1] = fx_neg(fx_mul(p01, hc));
                n[0][2] = fx_sub(fx_sub(c, pp), pg);
                n[1][0] = fx_neg(fx_mul(p10, hc));
                n[1][1] = fx_add(fx_add(fx_mul(p00, ha), fx_mul(p00, hc)), fx_mul(ha, hc));
                n[1][2] = fx_neg(fx_mul(p10, ha));
                n[2][0] = n[0][2];
                n[2][1] = fx_neg(fx_mul(p01, ha));
                n[2][2] = fx_add(fx_add(fx_add(fx_sub(pp, c), pg), fx_mul(p11, ha)),
                                 fx_mul(ha, hg));
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        fi[i][j] = fx_div(n[i][j], det);
                for (int j = 0; j < 3; j++) begin
                    k[0][j] = fx_add(fx_add(fx_mul(fi[0][j], u), fx_mul(fi[1][j], v)),
                                     fx_mul(fi[2][j], u));
                    k[1][j] = fx_add(fx_add(fx_mul(fi[0][j], p10), fx_mul(fi[1][j], p11)),
                                     fx_mul(fi[2][j], p10));
                end
                ea = fx_sub(za, est_ang);
                eg = fx_sub(zg, est_rate);
                ec = fx_sub(zc, est_ang);
                na = fx_add(fx_mul(dt, est_rate), fx_mul(k[0][0], ea));
                na = fx_add(fx_add(fx_add(na, fx_mul(k[0][1], eg)), fx_mul(k[0][2], ec)),
                            est_ang);
                nr = fx_add(fx_add(fx_add(fx_mul(k[1][0], ea), fx_mul(k[1][1], eg)),
                                   fx_mul(k[1][2], ec)), est_rate);
                est_ang = fx_wrap(na);
                est_rate = nr;
                s0 = fx_add(fx_sub(fx_neg(k[0][0]), k[0][2]), FX_ONE);
                s1 = fx_sub(fx_neg(k[1][0]), k[1][2]);
                t0 = fx_sub(dt, k[0][1]);
                t1 = fx_sub(FX_ONE, k[1][1]);
                p_aa = fx_add(fx_add(kf_reg[CFG_Q_ANGLE], fx_mul(t0, v)), fx_mul(u, s0));
                p_ar = fx_add(fx_mul(t1, v), fx_mul(s1, u));
                p_ra = fx_add(fx_mul(p10, s0), fx_mul(p11, t0));
                p_rr = fx_add(fx_add(fx_mul(p10, s1), fx_mul(p11, t1)), kf_reg[CFG_Q_RATE]);
            end
        end
        r.angle = est_ang[26:0];
        r.rate = est_rate[31:0];
        return r;
    endfunction

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_fused e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (fused_q.size() == 0) begin
                $error("result beat with no expected result: %h", m_axis_tdata);
                errors++;
            end else begin
                e = fused_q.pop_front();
                if (m_axis_tdata[26:0] !== e.angle) begin
                    $error("angle_out: expected %0d, got %0d", e.angle, m_axis_tdata[26:0]);
                    errors++;
                end
                if (m_axis_tdata[58:27] !== e.rate) begin
                    $error("rate_out: expected %0d, got %0d", $signed(e.rate),
                           $signed(m_axis_tdata[58:27]));
                    errors++;
                end
                if (m_axis_tdata[63:59] !== 5'd0) begin
                    $error("pad: expected 0, got %h", m_axis_tdata[63:59]);
                    errors++;
                end
                if (m_axis_tuser !== e.singular) begin
                    $error("singular: expected %0d, got %0d", e.singular, m_axis_tuser);
                    errors++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wd_cnt <= 0;
        else
            wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WD_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WD_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);

    // leaves tvalid high; the next call or drain_results drives it again
    task automatic send_meas(t_meas m);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {4'd0, m.v_compass, m.v_gyro, m.v_accel, m.dt,
                         m.compass, m.gyro, m.accel};
        s_axis_tuser <= m.reload;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fused_q.push_back(fuse_step(m));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (fused_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_INIT_ANGLE: kf_reg[idx] = val[26:0];
            CFG_INIT_RATE:  kf_reg[idx] = val;
            default:        kf_reg[idx] = val[30:0];
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_meas mk_meas(logic reload, longint za, longint zg, longint zc,
                                      longint dt, longint ha, longint hg, longint hc);
        t_meas m;
        m.reload = reload;
        m.accel = za[31:0]; m.gyro = zg[31:0]; m.compass = zc[31:0];
        m.dt = dt[30:0]; m.v_accel = ha[30:0]; m.v_gyro = hg[30:0]; m.v_compass = hc[30:0];
        return m;
    endfunction

    // plausible sensor data most of the time, raw bits now and then
    function automatic t_meas rand_meas();
        t_meas m;
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) begin
            m = mk_meas(1'b1, 0, 0, 0, 0, 0, 0, 0);
            m.accel = $urandom; m.gyro = $urandom; m.compass = $urandom;
            m.dt = 31'($urandom); m.v_accel = 31'($urandom);
        end else if (sel < 15) begin
            m.reload = 1'b0;
            m.accel = $urandom; m.gyro = $urandom; m.compass = $urandom;
            m.dt = 31'($urandom); m.v_accel = 31'($urandom); m.v_gyro = 31'($urandom);
            m.v_compass = 31'($urandom);
        end else begin
            m = mk_meas(1'b0,
                        longint'($urandom_range(105414357, 0)) - 2000000,
                        longint'($urandom_range(67108864, 0)) - 33554432,
                        longint'($urandom_range(105414357, 0)) + 1000000,
                        $urandom_range(4194304, 0),
                        $urandom_range(67108864, 1024),
                        $urandom_range(67108864, 1024),
                        $urandom_range(67108864, 1024));
        end
        return m;
    endfunction

    task automatic test_directed();
        // reset state and zero variances on both angle sensors: determinant zero
        send_meas(mk_meas(1'b0, 1000, 2000, 3000, 65536, 0, 16777216, 0));
        send_meas(mk_meas(1'b0, 16777216, 1677721, 16777216, 167772, 1677721, 1677721,
                          3355443));
        send_meas(mk_meas(1'b0, FX_HI, FX_HI, FX_HI, FX_HI, FX_HI, FX_HI, FX_HI));
        send_meas(mk_meas(1'b0, FX_LO, FX_LO, FX_LO, 0, 0, 0, 0));
        send_meas(mk_meas(1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_meas(mk_meas(1'b0, FX_LO, FX_HI, FX_LO, FX_HI, 1, 1, 1));
        send_meas(mk_meas(1'b0, -1, -1, -1, 1, FX_HI, 0, FX_HI));
        send_meas(mk_meas(1'b1, -1, -1, -1, FX_HI, FX_HI, FX_HI, FX_HI));
        // angles just around the wrap points
        send_meas(mk_meas(1'b0, TWO_PI, 0, TWO_PI + 1, 16777, 16777, 16777, 16777));
        send_meas(mk_meas(1'b0, -TWO_PI, 0, -1, 16777, 16777, 16777, 16777));
        send_meas(mk_meas(1'b0, 8 * TWO_PI, FX_LO, 3 * TWO_PI, FX_HI, 0, 0, 0));
        send_meas(mk_meas(1'b0, 1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 20,
                          1 << 20));
        drain_results();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_Q_ANGLE, 32'h7FFF_FFFF);
        write_reg(CFG_Q_RATE, 32'h0);
        write_reg(CFG_INIT_ANGLE, 32'd105414357);
        write_reg(CFG_INIT_RATE, 32'h8000_0000);
        write_reg(CFG_INIT_P_ANG, 32'h0);
        write_reg(CFG_INIT_P_RAT, 32'h7FFF_FFFF);
        send_meas(mk_meas(1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_meas(mk_meas(1'b0, 0, 0, 0, 16777216, 0, 0, 0));
        send_meas(mk_meas(1'b0, 5000000, -5000000, 6000000, 1677721, 1677721, 1677721,
                          1677721));
        drain_results();
        write_reg(CFG_Q_ANGLE, 32'h0);
        write_reg(CFG_Q_RATE, 32'h7FFF_FFFF);
        write_reg(CFG_INIT_ANGLE, 32'h0);
        write_reg(CFG_INIT_RATE, 32'h7FFF_FFFF);
        write_reg(CFG_INIT_P_ANG, 32'h7FFF_FFFF);
        write_reg(CFG_INIT_P_RAT, 32'h0);
        send_meas(mk_meas(1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_meas(mk_meas(1'b0, 1000000, 0, 2000000, 167772, 1677721, 1677721, 1677721));
        drain_results();
        // zero covariance everywhere: determinant of the variances alone
        write_reg(CFG_INIT_P_ANG, 32'h0);
        send_meas(mk_meas(1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_meas(mk_meas(1'b0, 1000000, 0, 2000000, 167772, 0, 1677721, 1677721));
        drain_results();
    endtask

    task automatic test_random(int n_items, int s_idle, int r_idle);
        send_idle = s_idle;
        rcv_idle = r_idle;
        for (int i = 0; i < n_items; i++) begin
            send_meas(rand_meas());
            // hold off until the output side is empty
            if (i == n_items / 2) drain_results();
        end
        drain_results();
    endtask

    task automatic set_typical_config(int q, int iang, int irate, int ip);
        write_reg(CFG_Q_ANGLE, q);
        write_reg(CFG_Q_RATE, q);
        write_reg(CFG_INIT_ANGLE, iang);
        write_reg(CFG_INIT_RATE, irate);
        write_reg(CFG_INIT_P_ANG, ip);
        write_reg(CFG_INIT_P_RAT, ip);
    endtask

    initial begin
        kf_reg[CFG_Q_ANGLE] = 16777;
        kf_reg[CFG_Q_RATE] = 16777;
        kf_reg[CFG_INIT_ANGLE] = 0;
        kf_reg[CFG_INIT_RATE] = 0;
        kf_reg[CFG_INIT_P_ANG] = 16777216;
        kf_reg[CFG_INIT_P_RAT] = 16777216;
        load_filter();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        set_typical_config(16777, 52707178, -8388608, 16777216);
        test_random(240, 7, 76);
        set_typical_config(167772, 1000, 4194304, 1677721);
        test_random(230, 76, 7);
        set_typical_config(1677, 105414357, 0, 167772160);
        test_random(230, 0, 0);

        repeat (100) @(posedge i_clk);
        $display("covered %0d filter steps (%0d singular), %0d reloads, %0d results checked",
                 n_steps, n_singular, n_reloads, n_results);
        $display("under sender and receiver stalls and several register settings");
        if (errors == 0 && fused_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* files.f */
hdl/kafs_pkg.sv
hdl/kalman_angle_fusion_step_top.sv
bench/kalman_angle_fusion_step_top_test.sv
